// File: rtl/rfrq_pkg.sv
// Shared types, constants and the CRC function of the frame resync queue.
package rfrq_pkg;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 16;
   localparam int MODE_W    = 2;
   localparam int EVENT_W   = 4;
   localparam int LEVEL_W   = 3;
   localparam int CSR_IDX_W = 1;

   // Stored window bytes; the eighth byte of a frame is taken straight from the input.
   localparam int WIN_BYTES = 7;
   localparam int CRC_SPAN  = 6;
   localparam int FILL_W    = 3;
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_BYTES);

   // Queue entry: function, address, value.
   localparam int ENTRY_W = BYTE_W + 2 * WORD_W;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [BYTE_W-1:0] STATION_RESET   = 8'd1;
   localparam logic [WORD_W-1:0] STOP_COIL_RESET = 16'd0;
   localparam logic [BYTE_W-1:0] FN_WRITE_COIL   = 8'd5;
   localparam logic [WORD_W-1:0] CRC_INIT        = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY        = 16'hA001;

   typedef enum logic [MODE_W-1:0] {
      MODE_RX   = 2'd0,
      MODE_POP  = 2'd1,
      MODE_TAKE = 2'd2
   } mode_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE          = 4'd0,
      EV_CRC_BAD_HERE  = 4'd1,
      EV_CRC_BAD_OTHER = 4'd2,
      EV_WRONG_STATION = 4'd3,
      EV_STOP_LATCHED  = 4'd4,
      EV_STOP_DUP      = 4'd5,
      EV_QUEUED        = 4'd6,
      EV_QUEUE_FULL    = 4'd7,
      EV_POPPED        = 4'd8,
      EV_POP_EMPTY     = 4'd9,
      EV_STOP_TAKEN    = 4'd10
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STATION   = 1'd0,
      CSR_STOP_COIL = 1'd1
   } csr_type;

   // Modbus CRC-16 over six bytes, byte 0 in the low bits. Every step is a
   // shift and a conditional XOR with a constant, so the whole function is a
   // flat XOR network of the 48 input bits.
   function automatic logic [WORD_W-1:0] crc16_frame(
      input logic [CRC_SPAN*BYTE_W-1:0] data
   );
      logic [WORD_W-1:0] crc;
      crc = CRC_INIT;
      for (int i = 0; i < CRC_SPAN; i++) begin
         crc = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data[i*BYTE_W +: BYTE_W]};
         for (int b = 0; b < BYTE_W; b++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
         end
      end
      return crc;
   endfunction

endpackage

// File: rtl/rfrq_req_if.sv
// Request channel: operation mode and received byte.
interface rfrq_req_if;
   logic                             valid;
   logic                             ready;
   logic [rfrq_pkg::MODE_W-1:0]      mode;
   logic [rfrq_pkg::BYTE_W-1:0]      rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// File: rtl/rfrq_rsp_if.sv
// Response channel: event code, delivered request and queue status.
interface rfrq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rfrq_pkg::EVENT_W-1:0]     event_res;
   logic [rfrq_pkg::BYTE_W-1:0]      req_function;
   logic [rfrq_pkg::WORD_W-1:0]      req_address;
   logic [rfrq_pkg::WORD_W-1:0]      req_value;
   logic [rfrq_pkg::LEVEL_W-1:0]     queue_level;
   logic                             stop_pending;
   logic [rfrq_pkg::LEVEL_W-1:0]     flushed_count;

   modport source (output valid, output event_res, output req_function, output req_address,
                   output req_value, output queue_level, output stop_pending,
                   output flushed_count, input ready);
   modport sink   (input valid, input event_res, input req_function, input req_address,
                   input req_value, input queue_level, input stop_pending,
                   input flushed_count, output ready);
endinterface

// File: rtl/rtu_frame_resync_queue.sv
// Modbus RTU frame resynchronizer with a request queue and a stop latch.
//
// Each request beat either feeds one received byte (MODE_RX), pops the oldest
// queued request (MODE_POP) or takes a latched stop request (MODE_TAKE), and
// produces exactly one response beat. Received bytes collect in an 8-byte
// window; on the eighth byte the Modbus CRC-16 of bytes 0..5 is checked against
// the little-endian CRC in bytes 6 and 7. A bad CRC drops the oldest byte so
// the window slides by one; a good CRC for a foreign station drops the whole
// frame. A good local frame that writes the configured stop coil off sets the
// stop latch, any other goes into a queue of QUEUE_DEPTH entries or is
// dropped when the queue is full. While a stop is latched, pops report
// nothing to pop; a stop take delivers the stop and flushes the queue. The
// block accepts one beat every cycle while req_chan.ready is high: all
// decisions are combinational between the state registers and a two-deep
// response buffer, and the CRC is a flat XOR network over the six stored
// payload bytes. Each response is registered in slot a or b. req_chan.ready
// drops only when both response slots are full, so a stalled response side
// still lets one more request in. Configuration writes take effect at the
// next clock edge and are meant to be done while no beat is in flight.
module rtu_frame_resync_queue #(
   parameter int QUEUE_DEPTH = rfrq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rfrq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rfrq_pkg::WORD_W-1:0]        csr_wdata,
   rfrq_req_if.sink                           req_chan,
   rfrq_rsp_if.source                         rsp_chan
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W:0]   DEPTH_PTR = (PTR_W + 1)'(QUEUE_DEPTH);

   localparam int BW = rfrq_pkg::BYTE_W;
   localparam int WW = rfrq_pkg::WORD_W;

   // Status part of a response; the request payload travels separately because
   // it may come straight from the queue memory.
   typedef struct packed {
      logic [rfrq_pkg::EVENT_W-1:0] event_res;
      logic [rfrq_pkg::LEVEL_W-1:0] queue_level;
      logic                         stop_pending;
      logic [rfrq_pkg::LEVEL_W-1:0] flushed_count;
   } rsp_meta_type;

   // Configuration registers.
   logic [BW-1:0] station_ff;
   logic [WW-1:0] stop_coil_ff;

   // Receive window.
   logic [BW-1:0]                 win_ff [rfrq_pkg::WIN_BYTES];
   logic [rfrq_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic                          win_store, win_shift;

   // Request queue.
   logic [rfrq_pkg::ENTRY_W-1:0]  fifo_mem [QUEUE_DEPTH];
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [PTR_W-1:0]              head_ff, head_in;
   logic [PTR_W-1:0]              tail;
   logic [PTR_W:0]                tail_sum, head_inc;
   logic                          push, pop_ok;
   logic                          stop_ff, stop_in;

   // Response buffer: slot a drives the port, slot b catches one more beat.
   logic                          a_valid_ff, b_valid_ff;
   rsp_meta_type                  a_meta_ff, b_meta_ff, meta_in;
   logic [rfrq_pkg::ENTRY_W-1:0]  a_data_ff, b_data_ff, fixed_data;

   // Frame decode.
   logic                          item_acc, a_take;
   logic [rfrq_pkg::CRC_SPAN*BW-1:0] crc_bytes;
   logic [WW-1:0]                 crc_calc, crc_recv;
   logic                          crc_ok, station_ok, is_stop;
   logic [BW-1:0]                 frame_fn;
   logic [WW-1:0]                 frame_addr, frame_val;
   logic [rfrq_pkg::ENTRY_W-1:0]  frame_entry;

   assign req_chan.ready = !b_valid_ff;
   assign item_acc       = req_chan.valid && req_chan.ready;
   assign a_take         = a_valid_ff && rsp_chan.ready;

   always_comb begin
      for (int i = 0; i < rfrq_pkg::CRC_SPAN; i++) begin
         crc_bytes[i*BW +: BW] = win_ff[i];
      end
   end

   assign crc_calc    = rfrq_pkg::crc16_frame(crc_bytes);
   assign crc_recv    = {req_chan.rx_byte, win_ff[rfrq_pkg::CRC_SPAN]};
   assign crc_ok      = (crc_calc == crc_recv);
   assign station_ok  = (win_ff[0] == station_ff);
   assign frame_fn    = win_ff[1];
   assign frame_addr  = {win_ff[2], win_ff[3]};
   assign frame_val   = {win_ff[4], win_ff[5]};
   assign frame_entry = {frame_fn, frame_addr, frame_val};
   assign is_stop     = (frame_fn == rfrq_pkg::FN_WRITE_COIL) &&
                        (frame_addr == stop_coil_ff) && (frame_val == '0);

   // New requests land behind the head, wrapping around the queue depth.
   assign tail_sum = (PTR_W + 1)'(head_ff) + (PTR_W + 1)'(count_ff);
   assign tail     = (tail_sum >= DEPTH_PTR) ? PTR_W'(tail_sum - DEPTH_PTR)
                                             : PTR_W'(tail_sum);
   assign head_inc = (PTR_W + 1)'(head_ff) + (PTR_W + 1)'(1);

   // Next state and response for the beat on the request channel.
   always_comb begin
      fill_in    = fill_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      stop_in    = stop_ff;
      win_store  = 1'b0;
      win_shift  = 1'b0;
      push       = 1'b0;
      pop_ok     = 1'b0;
      fixed_data = '0;
      meta_in    = '0;
      meta_in.event_res = rfrq_pkg::EV_NONE;

      case (req_chan.mode)
         rfrq_pkg::MODE_RX: begin
            if (fill_ff != rfrq_pkg::FILL_FULL) begin
               win_store = 1'b1;
               fill_in   = fill_ff + 1'b1;
            end else if (!crc_ok) begin
               // Slide by one byte and look for a frame start further on.
               win_shift = 1'b1;
               meta_in.event_res = station_ok ? rfrq_pkg::EV_CRC_BAD_HERE
                                              : rfrq_pkg::EV_CRC_BAD_OTHER;
            end else begin
               fill_in = '0;
               if (!station_ok) begin
                  meta_in.event_res = rfrq_pkg::EV_WRONG_STATION;
               end else if (is_stop) begin
                  meta_in.event_res = stop_ff ? rfrq_pkg::EV_STOP_DUP
                                              : rfrq_pkg::EV_STOP_LATCHED;
                  stop_in = 1'b1;
               end else if (count_ff >= DEPTH_CNT) begin
                  meta_in.event_res = rfrq_pkg::EV_QUEUE_FULL;
               end else begin
                  meta_in.event_res = rfrq_pkg::EV_QUEUED;
                  push     = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         rfrq_pkg::MODE_POP: begin
            // A latched stop outranks every queued request.
            if (stop_ff || count_ff == '0) begin
               meta_in.event_res = rfrq_pkg::EV_POP_EMPTY;
            end else begin
               meta_in.event_res = rfrq_pkg::EV_POPPED;
               pop_ok   = 1'b1;
               count_in = count_ff - 1'b1;
               head_in  = (head_inc == DEPTH_PTR) ? '0 : PTR_W'(head_inc);
            end
         end
         rfrq_pkg::MODE_TAKE: begin
            if (stop_ff) begin
               meta_in.event_res     = rfrq_pkg::EV_STOP_TAKEN;
               meta_in.flushed_count = rfrq_pkg::LEVEL_W'(count_ff);
               fixed_data = {rfrq_pkg::FN_WRITE_COIL, stop_coil_ff, {WW{1'b0}}};
               stop_in    = 1'b0;
               count_in   = '0;
               head_in    = '0;
            end
         end
         default: begin
         end
      endcase

      meta_in.queue_level  = rfrq_pkg::LEVEL_W'(count_in);
      meta_in.stop_pending = stop_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff   <= rfrq_pkg::STATION_RESET;
         stop_coil_ff <= rfrq_pkg::STOP_COIL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rfrq_pkg::CSR_STATION:   station_ff   <= csr_wdata[BW-1:0];
            rfrq_pkg::CSR_STOP_COIL: stop_coil_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Window bytes need no reset: the fill count marks which are valid.
   always_ff @(posedge clock) begin
      if (item_acc) begin
         for (int i = 0; i < rfrq_pkg::WIN_BYTES; i++) begin
            if (win_store && fill_ff == rfrq_pkg::FILL_W'(i)) begin
               win_ff[i] <= req_chan.rx_byte;
            end else if (win_shift) begin
               if (i == rfrq_pkg::WIN_BYTES - 1) begin
                  win_ff[i] <= req_chan.rx_byte;
               end else begin
                  win_ff[i] <= win_ff[i + 1];
               end
            end
         end
      end
   end

   // Queue memory.
   always_ff @(posedge clock) begin
      if (item_acc && push) begin
         fifo_mem[tail] <= frame_entry;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
         head_ff  <= '0;
         stop_ff  <= 1'b0;
      end else if (item_acc) begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         stop_ff  <= stop_in;
      end
   end

   // Response buffer. A new beat goes to slot a when it is free or being
   // emptied this cycle, otherwise to slot b. Popped payload is read from the
   // queue memory directly into the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (b_valid_ff) begin
            if (a_take) begin
               a_valid_ff <= 1'b1;
               b_valid_ff <= 1'b0;
            end
         end else if (item_acc) begin
            if (!a_valid_ff || a_take) begin
               a_valid_ff <= 1'b1;
            end else begin
               b_valid_ff <= 1'b1;
            end
         end else if (a_take) begin
            a_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         if (a_take) begin
            a_meta_ff <= b_meta_ff;
            a_data_ff <= b_data_ff;
         end
      end else if (item_acc) begin
         if (!a_valid_ff || a_take) begin
            a_meta_ff <= meta_in;
            a_data_ff <= pop_ok ? fifo_mem[head_ff] : fixed_data;
         end else begin
            b_meta_ff <= meta_in;
            b_data_ff <= pop_ok ? fifo_mem[head_ff] : fixed_data;
         end
      end
   end

   assign rsp_chan.valid         = a_valid_ff;
   assign rsp_chan.event_res     = a_meta_ff.event_res;
   assign rsp_chan.req_function  = a_data_ff[2*WW +: BW];
   assign rsp_chan.req_address   = a_data_ff[WW +: WW];
   assign rsp_chan.req_value     = a_data_ff[0 +: WW];
   assign rsp_chan.queue_level   = a_meta_ff.queue_level;
   assign rsp_chan.stop_pending  = a_meta_ff.stop_pending;
   assign rsp_chan.flushed_count = a_meta_ff.flushed_count;

`ifndef SYNTHESIS
   // The overflow slot is only ever used behind a waiting first slot.
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> a_valid_ff)
      else $error("response overflow slot full while the output slot is empty");

   // The queue never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count above depth");

   // A pop while a stop is latched must leave the queue alone.
   a_stop_blocks_pop: assert property (@(posedge clock) disable iff (reset)
      (item_acc && req_chan.mode == rfrq_pkg::MODE_POP && stop_ff)
      |=> ($stable(count_ff) && $stable(head_ff)))
      else $error("pop changed the queue while a stop was latched");

   // Taking a stop clears the latch and flushes the queue.
   a_take_flushes: assert property (@(posedge clock) disable iff (reset)
      (item_acc && req_chan.mode == rfrq_pkg::MODE_TAKE && stop_ff)
      |=> (!stop_ff && count_ff == '0 && head_ff == '0))
      else $error("stop take did not flush the queue");
`endif

endmodule
